FILE: sv/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 18;
  localparam int NUM_W     = VAL_W + 1;          // sum or difference of two entries
  localparam int ARG_W     = VAL_W + 1;          // positive root argument
  localparam int RT_W      = VAL_W;              // integer root of arg << FRAC_BITS
  localparam int X_W       = 2 * RT_W;           // radicand, two bits per root digit
  localparam int SR_W      = RT_W + 3;           // root remainder after shift-in
  localparam int D_W       = RT_W + 1;           // divisor 2r
  localparam int N_W       = NUM_W + FRAC_BITS;  // dividend |v| << F plus r
  localparam int QB        = VAL_W;              // quotient bits produced
  localparam int SLOTS     = 4;

  localparam logic [VAL_W-1:0] VAL_MAX  = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN  = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [QB-1:0]    Q_LIMIT  = {1'b1, {(QB-1){1'b0}}};

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [1:0]              slot_t;

  localparam slot_t SLOT_W = 2'd0;
  localparam slot_t SLOT_X = 2'd1;
  localparam slot_t SLOT_Y = 2'd2;
  localparam slot_t SLOT_Z = 2'd3;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [SR_W-1:0]  rem;
    logic [RT_W-1:0]  root;
    num_t [SLOTS-1:0] num;
    slot_t            main;
    logic             bad;
  } sq_t;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [QB-1:0]  low;
    logic [QB-1:0]  q;
    logic           neg;
    logic           zero;
    logic           ovf;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t [SLOTS-1:0] ln;
    logic [RT_W-1:0]      root;
    slot_t                main;
    logic                 bad;
  } dv_t;

endpackage

FILE: sv/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion, signed fixed point with 16 fraction bits
//
// input channel: the nine entries m00_i..m22_i with valid_i; a transfer
// happens on a clock edge with valid_i high and stall_o low
// output channel: qw_o, qx_o, qy_o, qz_o and bad_input_o with valid_o;
// a transfer happens on an edge with valid_o high and stall_i low
// throughput: one matrix per cycle while no stall holds the pipeline
// from input transfer to valid_o: a register stage selects the path and
// forms the root argument, the digit-by-digit root follows (one result bit
// per stage), a register forms the dividends, restoring dividers follow in
// four parallel lanes (one quotient bit per stage), and saturation feeds
// the output register
// bad_input_o marks a non-positive root argument or a saturated part
// reset clears every valid bit; the pipeline comes up empty
// a stall with valid_o high freezes the whole pipeline and raises stall_o
// in the same cycle; nothing is dropped or repeated
module rotation_matrix_to_quaternion (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m00_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m01_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m02_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m10_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m11_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m12_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m20_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m21_i,
  input  logic signed [rmq_pkg::VAL_W-1:0]    m22_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [rmq_pkg::VAL_W-1:0]    qw_o,
  output logic signed [rmq_pkg::VAL_W-1:0]    qx_o,
  output logic signed [rmq_pkg::VAL_W-1:0]    qy_o,
  output logic signed [rmq_pkg::VAL_W-1:0]    qz_o,
  output logic                                bad_input_o
);
  import rmq_pkg::*;

  function automatic num_t sub2(input logic signed [VAL_W-1:0] a,
                                input logic signed [VAL_W-1:0] b);
    return NUM_W'(a) - NUM_W'(b);
  endfunction

  function automatic num_t add2(input logic signed [VAL_W-1:0] a,
                                input logic signed [VAL_W-1:0] b);
    return NUM_W'(a) + NUM_W'(b);
  endfunction

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // path select and root argument
  logic signed [VAL_W+1:0] tr;
  logic signed [VAL_W+2:0] arg;
  sq_t                     prep;

  always_comb begin
    tr   = (VAL_W+2)'(m00_i) + (VAL_W+2)'(m11_i) + (VAL_W+2)'(m22_i);
    prep = '0;
    if (tr > 0) begin
      arg              = (VAL_W+3)'(tr) + (VAL_W+3)'(1 << FRAC_BITS);
      prep.main        = SLOT_W;
      prep.num[SLOT_X] = sub2(m21_i, m12_i);
      prep.num[SLOT_Y] = sub2(m02_i, m20_i);
      prep.num[SLOT_Z] = sub2(m10_i, m01_i);
    end else if (m22_i > ((m11_i > m00_i) ? m11_i : m00_i)) begin
      arg              = (VAL_W+3)'(m22_i) - ((VAL_W+3)'(m00_i) + (VAL_W+3)'(m11_i))
                         + (VAL_W+3)'(1 << FRAC_BITS);
      prep.main        = SLOT_Z;
      prep.num[SLOT_W] = sub2(m10_i, m01_i);
      prep.num[SLOT_X] = add2(m02_i, m20_i);
      prep.num[SLOT_Y] = add2(m12_i, m21_i);
    end else if (m11_i > m00_i) begin
      arg              = (VAL_W+3)'(m11_i) - ((VAL_W+3)'(m22_i) + (VAL_W+3)'(m00_i))
                         + (VAL_W+3)'(1 << FRAC_BITS);
      prep.main        = SLOT_Y;
      prep.num[SLOT_W] = sub2(m02_i, m20_i);
      prep.num[SLOT_Z] = add2(m21_i, m12_i);
      prep.num[SLOT_X] = add2(m01_i, m10_i);
    end else begin
      arg              = (VAL_W+3)'(m00_i) - ((VAL_W+3)'(m11_i) + (VAL_W+3)'(m22_i))
                         + (VAL_W+3)'(1 << FRAC_BITS);
      prep.main        = SLOT_X;
      prep.num[SLOT_W] = sub2(m21_i, m12_i);
      prep.num[SLOT_Y] = add2(m10_i, m01_i);
      prep.num[SLOT_Z] = add2(m20_i, m02_i);
    end
    if (arg <= 0) begin
      prep.bad = 1'b1;
      prep.x   = '0;
    end else begin
      prep.x = {1'b0, arg[ARG_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // root pipeline: stage k settles root bit RT_W-1-k
  sq_t  sq_q [RT_W+1];
  logic sqv_q [RT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q[0] <= 1'b0;
    end else if (en) begin
      sqv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= prep;
    end
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    logic [SR_W-1:0] rem_sh;
    logic [SR_W-1:0] trial;
    logic            take;
    sq_t             nxt_d;

    always_comb begin
      rem_sh = {sq_q[k].rem[SR_W-3:0], sq_q[k].x[X_W-1-2*k -: 2]};
      trial  = {1'b0, sq_q[k].root, 2'b01};
      take   = rem_sh >= trial;
      nxt_d      = sq_q[k];
      nxt_d.rem  = take ? rem_sh - trial : rem_sh;
      nxt_d.root = {sq_q[k].root[RT_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k+1] <= 1'b0;
      end else if (en) begin
        sqv_q[k+1] <= sqv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k+1] <= nxt_d;
      end
    end
  end

  // dividends |v| << F plus r over divisor 2r, rounded half away from zero
  dv_t dv_d;

  always_comb begin
    logic [D_W-1:0]     dvs;
    logic [NUM_W-1:0]   mag;
    logic [N_W-1:0]     nn;
    dvs       = {sq_q[RT_W].root, 1'b0};
    dv_d      = '0;
    dv_d.root = sq_q[RT_W].root;
    dv_d.main = sq_q[RT_W].main;
    dv_d.bad  = sq_q[RT_W].bad;
    for (int s = 0; s < SLOTS; s++) begin
      mag = sq_q[RT_W].num[s][NUM_W-1] ? NUM_W'(-$signed(sq_q[RT_W].num[s]))
                                       : sq_q[RT_W].num[s];
      nn  = {mag, {FRAC_BITS{1'b0}}} + N_W'(sq_q[RT_W].root);
      dv_d.ln[s].neg  = sq_q[RT_W].num[s][NUM_W-1];
      dv_d.ln[s].zero = sq_q[RT_W].num[s] == '0;
      dv_d.ln[s].ovf  = (QB+D_W)'(nn) >= {dvs, {QB{1'b0}}};
      dv_d.ln[s].rem  = D_W'(nn[N_W-1:QB]);
      dv_d.ln[s].low  = nn[QB-1:0];
    end
  end

  dv_t  dv_q [QB+1];
  logic dvv_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (en) begin
      dvv_q[0] <= sqv_q[RT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= dv_d;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    dv_t nxt_d;

    always_comb begin
      logic [D_W:0] t;
      logic [D_W:0] dd;
      dd    = {1'b0, dv_q[k].root, 1'b0};
      nxt_d = dv_q[k];
      for (int s = 0; s < SLOTS; s++) begin
        t = {dv_q[k].ln[s].rem, dv_q[k].ln[s].low[QB-1-k]};
        if (t >= dd) begin
          nxt_d.ln[s].rem = D_W'(t - dd);
          nxt_d.ln[s].q   = {dv_q[k].ln[s].q[QB-2:0], 1'b1};
        end else begin
          nxt_d.ln[s].rem = D_W'(t);
          nxt_d.ln[s].q   = {dv_q[k].ln[s].q[QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else if (en) begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[k+1] <= nxt_d;
      end
    end
  end

  // saturation and output register
  logic [VAL_W-1:0] part_d [SLOTS];
  logic             bad_d;

  always_comb begin
    dv_lane_t ln;
    bad_d = dv_q[QB].bad;
    for (int s = 0; s < SLOTS; s++) begin
      ln = dv_q[QB].ln[s];
      if (slot_t'(s) == dv_q[QB].main) begin
        part_d[s] = {1'b0, dv_q[QB].root[RT_W-1:1]};
      end else if (ln.zero) begin
        part_d[s] = '0;
      end else if (ln.neg) begin
        if (ln.ovf || ln.q > Q_LIMIT) begin
          part_d[s] = VAL_MIN;
          bad_d     = 1'b1;
        end else begin
          part_d[s] = VAL_W'(-ln.q);
        end
      end else begin
        if (ln.ovf || ln.q >= Q_LIMIT) begin
          part_d[s] = VAL_MAX;
          bad_d     = 1'b1;
        end else begin
          part_d[s] = ln.q;
        end
      end
    end
  end

  logic             valid_q;
  logic [VAL_W-1:0] qw_q, qx_q, qy_q, qz_q;
  logic             bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= dvv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qw_q  <= part_d[SLOT_W];
      qx_q  <= part_d[SLOT_X];
      qy_q  <= part_d[SLOT_Y];
      qz_q  <= part_d[SLOT_Z];
      bad_q <= bad_d;
    end
  end

  assign valid_o     = valid_q;
  assign qw_o        = qw_q;
  assign qx_o        = qx_q;
  assign qy_o        = qy_q;
  assign qz_o        = qz_q;
  assign bad_input_o = bad_q;

endmodule

FILE: sv/rmq_checker.sv
module rmq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             stall_o,
  input logic                             valid_o,
  input logic                             stall_i,
  input logic signed [rmq_pkg::VAL_W-1:0] qw_o,
  input logic signed [rmq_pkg::VAL_W-1:0] qx_o,
  input logic signed [rmq_pkg::VAL_W-1:0] qy_o,
  input logic signed [rmq_pkg::VAL_W-1:0] qz_o,
  input logic                             bad_input_o
);
  import rmq_pkg::*;

  // the block only backs up when a finished result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o without a held result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(qw_o) && $stable(qx_o)
                              && $stable(qy_o) && $stable(qz_o)
                              && $stable(bad_input_o)))
    else $error("stalled result changed");

  // a good result always has a main part of at least half the smallest root
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && qw_o == '0 && qx_o == '0 && qy_o == '0 && qz_o == '0)
      |-> bad_input_o)
    else $error("all-zero quaternion not flagged");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .stall_o     (stall_o),
  .valid_o     (valid_o),
  .stall_i     (stall_i),
  .qw_o        (qw_o),
  .qx_o        (qx_o),
  .qy_o        (qy_o),
  .qz_o        (qz_o),
  .bad_input_o (bad_input_o)
);

FILE: tb/sv/rotation_matrix_to_quaternion_tb.sv
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int LATENCY = 39;
  localparam int N_RANDOM = 1030;

  typedef logic signed [VAL_W-1:0] fx_t;
  typedef fx_t mat_t [9];

  typedef struct {
    fx_t qw, qx, qy, qz;
    logic bad;
  } quat_t;

  typedef struct {
    mat_t m;
    logic known;
    quat_t q;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o, bad_input_o;
  fx_t m00_i = '0, m01_i = '0, m02_i = '0, m10_i = '0, m11_i = '0;
  fx_t m12_i = '0, m20_i = '0, m21_i = '0, m22_i = '0;
  fx_t qw_o, qx_o, qy_o, qz_o;

  quat_t pending_quats[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_bad = 0;
  logic recv_active = 1'b0;

  always #6 clk_i = ~clk_i;

  rotation_matrix_to_quaternion uut (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .valid_o, .stall_i, .qw_o, .qx_o, .qy_o, .qz_o, .bad_input_o
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // v / (2 r) in fixed point, rounded half away from zero
  function automatic longint scale_by_root(longint v, longint unsigned r);
    longint unsigned mag, qq;
    if (v == 0) return 0;
    if (r == 0) return v > 0 ? 64'sd131072 : -64'sd131073;
    mag = v < 0 ? -v : v;
    qq = ((mag << FRAC_BITS) + r) / (2 * r);
    if (qq > 131073) qq = 131073;
    return v < 0 ? -longint'(qq) : longint'(qq);
  endfunction

  function automatic fx_t saturate(longint v, ref logic bad);
    if (v > 131071) begin
      bad = 1'b1;
      return VAL_MAX;
    end
    if (v < -131072) begin
      bad = 1'b1;
      return VAL_MIN;
    end
    return fx_t'(v);
  endfunction

  function automatic quat_t matrix_to_quat(mat_t mi);
    longint m[3][3];
    longint q[4];
    longint tr, arg;
    longint unsigned r;
    int i, j, k;
    logic bad;
    quat_t res;
    bad = 1'b0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++) m[a][b] = mi[a*3+b];
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      arg = tr + (64'sd1 << FRAC_BITS);
      r = int_sqrt(longint'(arg) << FRAC_BITS);
      q[0] = r >> 1;
      q[1] = scale_by_root(m[2][1] - m[1][2], r);
      q[2] = scale_by_root(m[0][2] - m[2][0], r);
      q[3] = scale_by_root(m[1][0] - m[0][1], r);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - (m[j][j] + m[k][k]) + (64'sd1 << FRAC_BITS);
      if (arg <= 0) begin
        bad = 1'b1;
        r = 0;
      end else begin
        r = int_sqrt(longint'(arg) << FRAC_BITS);
      end
      q[i+1] = r >> 1;
      q[0] = scale_by_root(m[k][j] - m[j][k], r);
      q[j+1] = scale_by_root(m[j][i] + m[i][j], r);
      q[k+1] = scale_by_root(m[k][i] + m[i][k], r);
    end
    res.qw = saturate(q[0], bad);
    res.qx = saturate(q[1], bad);
    res.qy = saturate(q[2], bad);
    res.qz = saturate(q[3], bad);
    res.bad = bad;
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 60);
  endfunction

  function automatic fx_t rand_fx();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return fx_t'($urandom_range(0, 131072) - 65536);
      3: return fx_t'($urandom_range(0, 8192) - 4096);
      default: return fx_t'($urandom);
    endcase
  endfunction

  // mostly proper rotations built from a random unit quaternion
  function automatic mat_t rand_matrix();
    mat_t m;
    real a, b, c, d, n, e[9];
    if ($urandom_range(0, 3) == 0) begin
      foreach (m[t]) m[t] = rand_fx();
      return m;
    end
    a = $urandom_range(0, 20000) - 10000.0;
    b = $urandom_range(0, 20000) - 10000.0;
    c = $urandom_range(0, 20000) - 10000.0;
    d = $urandom_range(0, 20000) - 10000.0;
    n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
    a /= n; b /= n; c /= n; d /= n;
    e[0] = 1 - 2*(c*c + d*d); e[1] = 2*(b*c - a*d); e[2] = 2*(b*d + a*c);
    e[3] = 2*(b*c + a*d); e[4] = 1 - 2*(b*b + d*d); e[5] = 2*(c*d - a*b);
    e[6] = 2*(b*d - a*c); e[7] = 2*(c*d + a*b); e[8] = 1 - 2*(b*b + c*c);
    foreach (m[t]) m[t] = fx_t'($rtoi(e[t] * 65536.0) + $urandom_range(0, 6) - 3);
    return m;
  endfunction

  // valid_i only drops when a gap follows, so back-to-back transfers keep it high
  task automatic send_matrix(mat_t m, logic known, quat_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    {m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    pending_quats.push_back(known ? q : matrix_to_quat(m));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      quat_t e;
      if (pending_quats.size() == 0) begin
        $error("result with no matrix outstanding");
        errors++;
      end else begin
        e = pending_quats.pop_front();
        n_recv++;
        if (bad_input_o) n_bad++;
        if (qw_o !== e.qw) begin
          $error("qw expected %0d got %0d", e.qw, qw_o); errors++;
        end
        if (qx_o !== e.qx) begin
          $error("qx expected %0d got %0d", e.qx, qx_o); errors++;
        end
        if (qy_o !== e.qy) begin
          $error("qy expected %0d got %0d", e.qy, qy_o); errors++;
        end
        if (qz_o !== e.qz) begin
          $error("qz expected %0d got %0d", e.qz, qz_o); errors++;
        end
        if (bad_input_o !== e.bad) begin
          $error("bad_input expected %0b got %0b", e.bad, bad_input_o); errors++;
        end
      end
    end
  end

  // receiver stalls in bursts, with calm stretches
  always @(posedge clk_i) begin
    if (!recv_active) stall_i <= 1'b0;
    else if ($urandom_range(0, 499) == 0) stall_i <= 1'b1;
    else if (stall_i) stall_i <= ($urandom_range(0, 9) != 0);
    else stall_i <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    localparam fx_t ONE = 18'sd65536;
    stim_row_t dir[$];
    stim_row_t row;
    quat_t z;
    z = '{default: '0};
    // identity: qw = 1/2 * sqrt(4) = 1.0
    dir.push_back('{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1,
                    '{18'sd65536, 0, 0, 0, 1'b0}});
    // all zero: trace 0, root of 1
    dir.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
                    '{0, 18'sd32768, 0, 0, 1'b0}});
    // 180 degrees about each axis
    dir.push_back('{'{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b1,
                    '{0, 18'sd65536, 0, 0, 1'b0}});
    dir.push_back('{'{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}, 1'b1,
                    '{0, 0, 18'sd65536, 0, 1'b0}});
    dir.push_back('{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}, 1'b1,
                    '{0, 0, 0, 18'sd65536, 1'b0}});
    // equal negative diagonal, the tie picks the x axis
    dir.push_back('{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b0, z});
    // negative diagonal, numerators of both signs
    dir.push_back('{'{-ONE, 100, -100, 50, -ONE, 7, 3, -9, -ONE}, 1'b0, z});
    dir.push_back('{'{VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX,
                      VAL_MIN, VAL_MAX, VAL_MIN}, 1'b0, z});
    dir.push_back('{'{VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX,
                      VAL_MAX, VAL_MAX, VAL_MAX}, 1'b0, z});
    dir.push_back('{'{VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN,
                      VAL_MAX, VAL_MIN, VAL_MAX}, 1'b0, z});
    dir.push_back('{'{VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN,
                      VAL_MIN, VAL_MIN, VAL_MIN}, 1'b0, z});
    // tiny positive trace with large skew saturates
    dir.push_back('{'{1, VAL_MIN, VAL_MAX, VAL_MAX, 0, VAL_MIN, VAL_MIN, VAL_MAX, 0},
                    1'b0, z});
    // diagonal ties exercise the strict comparisons
    dir.push_back('{'{-ONE/2, 11, 22, 33, -ONE/2, 44, 55, 66, -ONE/2}, 1'b0, z});
    dir.push_back('{'{-ONE/4, 11, 22, 33, -ONE, 44, 55, 66, -ONE/4}, 1'b0, z});
    dir.push_back('{'{-ONE, 5, -5, 6, -ONE/4, -6, 7, -7, -ONE/4}, 1'b0, z});
    // small 90 degree rotations
    dir.push_back('{'{ONE, 0, 0, 0, 0, -ONE, 0, ONE, 0}, 1'b0, z});
    dir.push_back('{'{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}, 1'b0, z});
    dir.push_back('{'{0, 0, ONE, 0, ONE, 0, -ONE, 0, 0}, 1'b0, z});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    recv_active <= 1'b1;

    foreach (dir[t]) send_matrix(dir[t].m, dir[t].known, dir[t].q);
    for (int t = 0; t < N_RANDOM; t++) begin
      // hold off until the pipeline has drained
      if (t == N_RANDOM / 2) begin
        valid_i <= 1'b0;
        while (pending_quats.size() != 0) @(posedge clk_i);
      end
      send_matrix(rand_matrix(), 1'b0, z);
    end
    valid_i <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d matrices (directed corners, rotations, raw patterns)", n_sent);
    $display("checked %0d quaternions, %0d flagged bad", n_recv, n_bad);
    if (errors == 0 && pending_quats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/rmq_pkg.sv
sv/rotation_matrix_to_quaternion.sv
sv/rmq_checker.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
